// ----- rtl/core/jpse_pkg.sv -----
package jpse_pkg;

    // Table depth default.
    localparam int NUM_ENTRIES_DEF = 32;

    // Field widths of one input beat and one output beat.
    localparam int OP_W      = 2;
    localparam int ID_W      = 29;
    localparam int DATA_W    = 64;
    localparam int EIDX_W    = 5;
    localparam int GROUP_W   = 18;
    localparam int POS_W     = 6;
    localparam int LEN_W     = 7;
    localparam int STATUS_W  = 1;
    localparam int COUNT_W   = 5;

    // Slave tdata layout, lowest field first, padded to whole bytes.
    localparam int S_OP_LSB    = 0;
    localparam int S_ID_LSB    = S_OP_LSB + OP_W;
    localparam int S_DATA_LSB  = S_ID_LSB + ID_W;
    localparam int S_EIDX_LSB  = S_DATA_LSB + DATA_W;
    localparam int S_GROUP_LSB = S_EIDX_LSB + EIDX_W;
    localparam int S_POS_LSB   = S_GROUP_LSB + GROUP_W;
    localparam int S_LEN_LSB   = S_POS_LSB + POS_W;
    localparam int S_USED_W    = S_LEN_LSB + LEN_W;
    localparam int S_TDATA_W   = ((S_USED_W + 7) / 8) * 8;

    // Master tdata layout.
    localparam int M_VALUE_LSB  = 0;
    localparam int M_STATUS_LSB = M_VALUE_LSB + DATA_W;
    localparam int M_COUNT_LSB  = M_STATUS_LSB + STATUS_W;
    localparam int M_USED_W     = M_COUNT_LSB + COUNT_W;
    localparam int M_TDATA_W    = ((M_USED_W + 7) / 8) * 8;

    // Packed table entry: group, position, length (length lowest).
    localparam int ENTRY_W     = GROUP_W + POS_W + LEN_W;
    localparam int E_LEN_LSB   = 0;
    localparam int E_POS_LSB   = E_LEN_LSB + LEN_W;
    localparam int E_GROUP_LSB = E_POS_LSB + POS_W;

    // J1939 group number derivation.
    localparam logic [7:0]         PF_LIMIT        = 8'hF0;
    localparam logic [7:0]         BYTE_MASK       = 8'hFF;
    localparam logic [GROUP_W-1:0] GROUP_PDU1_MASK = 18'h3FF00;
    localparam logic [GROUP_W-1:0] GROUP_PDU2_MASK = 18'h3FFFF;
    localparam logic [COUNT_W-1:0] COUNT_MAX       = 5'd31;

    localparam logic [STATUS_W-1:0] STATUS_OK  = 1'b0;
    localparam logic [STATUS_W-1:0] STATUS_ERR = 1'b1;

    typedef enum logic [OP_W-1:0] {
        OP_FRAME = 2'd0,
        OP_READ  = 2'd1,
        OP_PROG  = 2'd2
    } t_opcode;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_DRAIN,
        S_READ,
        S_DONE
    } t_state;

    // Controller to datapath commands.
    typedef struct packed {
        logic capture;
        logic scan_start;
        logic scan_issue;
        logic val_read;
        logic prog;
        logic out_load;
    } t_dp_cmd;

    // Datapath to controller status.
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            scan_last;
    } t_dp_stat;

endpackage

// ----- rtl/core/jpse_ram.sv -----
module jpse_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port, one registered read port; read data holds between reads.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/jpse_ctrl.sv -----
module jpse_ctrl
    import jpse_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_s_tvalid,
    output logic     o_s_tready,
    output logic     o_m_tvalid,
    input  logic     i_m_tready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   out_free;

    // The output slot can take a result when empty or being drained now.
    assign out_free = !r_out_valid || i_m_tready;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                case (i_stat.op)
                    OP_FRAME: n_state = S_SCAN;
                    OP_READ:  n_state = S_READ;
                    default:  n_state = S_DONE;
                endcase
            end
            S_SCAN: begin
                if (i_stat.scan_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: n_state = S_DONE;
            S_READ:  n_state = S_DONE;
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Commands to the datapath.
    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            S_IDLE: o_cmd.capture = i_s_tvalid;
            S_DECODE: begin
                case (i_stat.op)
                    OP_FRAME: o_cmd.scan_start = 1'b1;
                    OP_READ:  o_cmd.val_read   = 1'b1;
                    OP_PROG:  o_cmd.prog       = 1'b1;
                    default:  o_cmd = '0;
                endcase
            end
            S_SCAN:  o_cmd.scan_issue = 1'b1;
            S_DONE:  o_cmd.out_load = out_free;
            default: o_cmd = '0;
        endcase
    end

    // State register and output beat valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_valid;

    // A new result never overwrites one that is still waiting.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> (!r_out_valid || i_m_tready))
        else $error("result loaded over a pending beat");

    // An accepted beat always goes to decode next.
    a_accept_decode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> (r_state == S_DECODE))
        else $error("accepted beat not decoded");

    // The scan ends with a drain state, followed by the result state.
    a_drain_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DRAIN) |=> (r_state == S_DONE))
        else $error("drain not followed by result");

endmodule

// ----- rtl/core/jpse_datapath.sv -----
module jpse_datapath
    import jpse_pkg::*;
#(
    parameter int NUM_ENTRIES = NUM_ENTRIES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [S_TDATA_W-1:0] i_s_tdata,
    input  t_dp_cmd              i_cmd,
    output t_dp_stat             o_stat,
    output logic [M_TDATA_W-1:0] o_m_tdata
);

    localparam int IDX_W = $clog2(NUM_ENTRIES);
    localparam int EXT_W = IDX_W + EIDX_W;

    // Captured input beat.
    logic [OP_W-1:0]    r_op;
    logic [ID_W-1:0]    r_id;
    logic [DATA_W-1:0]  r_data;
    logic [EIDX_W-1:0]  r_idx;
    logic [GROUP_W-1:0] r_grp;
    logic [POS_W-1:0]   r_pos;
    logic [LEN_W-1:0]   r_len;

    logic [NUM_ENTRIES-1:0] r_valid;
    logic [IDX_W-1:0]       r_scan_idx;
    logic                   r_proc_vld;
    logic [IDX_W-1:0]       r_proc_idx;
    logic [COUNT_W-1:0]     r_count;

    logic [DATA_W-1:0]   r_out_value;
    logic [STATUS_W-1:0] r_out_status;
    logic [COUNT_W-1:0]  r_out_count;

    logic [EXT_W-1:0]   idx_ext;
    logic [IDX_W-1:0]   idx_addr;
    logic               idx_ok;
    logic               read_ok;
    logic               prog_wr;
    logic [GROUP_W-1:0] frame_grp;
    logic [ENTRY_W-1:0] ent_rdata;
    logic [GROUP_W-1:0] ent_grp;
    logic [POS_W-1:0]   ent_pos;
    logic [LEN_W-1:0]   ent_len;
    logic               hit;
    logic [DATA_W-1:0]  field_mask;
    logic [DATA_W-1:0]  field;
    logic               val_we;
    logic [IDX_W-1:0]   val_waddr;
    logic [DATA_W-1:0]  val_wdata;
    logic [DATA_W-1:0]  val_rdata;
    logic [DATA_W-1:0]  res_value;
    logic [STATUS_W-1:0] res_status;
    logic [COUNT_W-1:0] res_count;

    // Capture the fields of an accepted beat.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op   <= i_s_tdata[S_OP_LSB +: OP_W];
            r_id   <= i_s_tdata[S_ID_LSB +: ID_W];
            r_data <= i_s_tdata[S_DATA_LSB +: DATA_W];
            r_idx  <= i_s_tdata[S_EIDX_LSB +: EIDX_W];
            r_grp  <= i_s_tdata[S_GROUP_LSB +: GROUP_W];
            r_pos  <= i_s_tdata[S_POS_LSB +: POS_W];
            r_len  <= i_s_tdata[S_LEN_LSB +: LEN_W];
        end
    end

    // Index check: entry zero is reserved, and the index must fit the table.
    assign idx_ext  = {{IDX_W{1'b0}}, r_idx};
    assign idx_addr = idx_ext[IDX_W-1:0];
    assign idx_ok   = (r_idx != '0) && (idx_ext < EXT_W'(NUM_ENTRIES));
    assign read_ok  = idx_ok && r_valid[idx_addr];
    assign prog_wr  = i_cmd.prog && idx_ok;

    // Group number: the destination byte is dropped for PDU1 formats.
    assign frame_grp = r_id[8 +: GROUP_W] &
        (((r_id[16 +: 8] & BYTE_MASK) < PF_LIMIT) ? GROUP_PDU1_MASK : GROUP_PDU2_MASK);

    // Entry valid marks.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (prog_wr) begin
            r_valid[idx_addr] <= 1'b1;
        end
    end

    // Entry table: group, position and length per index.
    jpse_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NUM_ENTRIES)
    ) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (prog_wr),
        .i_waddr (idx_addr),
        .i_wdata ({r_grp, r_pos, r_len}),
        .i_re    (i_cmd.scan_issue),
        .i_raddr (r_scan_idx),
        .o_rdata (ent_rdata)
    );

    // Scan address counter and the read-data pipeline stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_idx <= '0;
            r_proc_vld <= 1'b0;
        end else begin
            r_proc_vld <= i_cmd.scan_issue;
            if (i_cmd.scan_start) begin
                r_scan_idx <= IDX_W'(1);
            end else if (i_cmd.scan_issue) begin
                r_scan_idx <= r_scan_idx + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_proc_idx <= r_scan_idx;
    end

    assign o_stat.scan_last = (r_scan_idx == IDX_W'(NUM_ENTRIES - 1));
    assign o_stat.op        = r_op;

    // Match and bit-field extraction for the entry read last cycle.
    assign ent_grp = ent_rdata[E_GROUP_LSB +: GROUP_W];
    assign ent_pos = ent_rdata[E_POS_LSB +: POS_W];
    assign ent_len = ent_rdata[E_LEN_LSB +: LEN_W];
    assign hit     = r_proc_vld && r_valid[r_proc_idx] && (ent_grp == frame_grp);

    // Lengths of 64 and above keep the whole shifted payload.
    assign field_mask = ent_len[LEN_W-1] ? {DATA_W{1'b1}}
                                         : ~({DATA_W{1'b1}} << ent_len[LEN_W-2:0]);
    assign field      = (r_data >> ent_pos) & field_mask;

    // Matches counter, saturating.
    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_start) begin
            r_count <= '0;
        end else if (hit && (r_count != COUNT_MAX)) begin
            r_count <= r_count + COUNT_W'(1);
        end
    end

    // Value table: scan results, or zero when an entry is programmed.
    assign val_we    = hit || prog_wr;
    assign val_waddr = hit ? r_proc_idx : idx_addr;
    assign val_wdata = hit ? field : '0;

    jpse_ram #(
        .WIDTH (DATA_W),
        .DEPTH (NUM_ENTRIES)
    ) u_value_ram (
        .i_clk   (i_clk),
        .i_we    (val_we),
        .i_waddr (val_waddr),
        .i_wdata (val_wdata),
        .i_re    (i_cmd.val_read),
        .i_raddr (idx_addr),
        .o_rdata (val_rdata)
    );

    // Result fields by opcode.
    always_comb begin
        res_value  = '0;
        res_status = STATUS_ERR;
        res_count  = '0;
        case (r_op)
            OP_FRAME: begin
                res_status = STATUS_OK;
                res_count  = r_count;
            end
            OP_READ: begin
                res_status = read_ok ? STATUS_OK : STATUS_ERR;
                res_value  = read_ok ? val_rdata : '0;
            end
            OP_PROG: res_status = idx_ok ? STATUS_OK : STATUS_ERR;
            default: res_status = STATUS_ERR;
        endcase
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_value  <= res_value;
            r_out_status <= res_status;
            r_out_count  <= res_count;
        end
    end

    assign o_m_tdata = {{(M_TDATA_W - M_USED_W){1'b0}}, r_out_count, r_out_status, r_out_value};

    // Scan writes and programming writes never collide on the value table.
    a_val_wr_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(hit && prog_wr))
        else $error("value table write collision");

    // The reserved entry never becomes valid.
    a_rsvd_invalid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_valid[0])
        else $error("reserved entry marked valid");

    // A scan hit only ever lands on a programmed entry.
    a_hit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        hit |-> (r_proc_idx != '0))
        else $error("scan hit on reserved entry");

endmodule

// ----- rtl/core/j1939_pgn_signal_extractor_top.sv -----
// Channel | Direction | Handshake             | Payload
// slave   | in        | i_s_tvalid/o_s_tready | i_s_tdata: opcode, can_id, frame_data, entry
// master  | out       | o_m_tvalid/i_m_tready | o_m_tdata: value, status, match_count
//
// One beat in flight at a time. A frame's result comes from a scan of the entry RAM one
// index per cycle from index 1, between the decode and the drain state;
// the next beat can be taken in the cycle after the result is loaded.
// A read passes the registered read of the value RAM; a program or bad opcode does not.
// Reset is synchronous: it clears the valid marks and the control; no clearing pass.
// A result waits in the output register while the next beat is accepted; a stalled
// master holds back only the completion of that next beat.
module j1939_pgn_signal_extractor_top
    import jpse_pkg::*;
#(
    parameter int NUM_ENTRIES = NUM_ENTRIES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    // opcode, can_id, frame_data, entry_index, entry_group, entry_pos, entry_len
    input  logic [S_TDATA_W-1:0] i_s_tdata,
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    // value, status, match_count
    output logic [M_TDATA_W-1:0] o_m_tdata
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    // Sequencer.
    jpse_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd)
    );

    // Tables, extractor and result register.
    jpse_datapath #(
        .NUM_ENTRIES (NUM_ENTRIES)
    ) u_datapath (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_tdata (i_s_tdata),
        .i_cmd     (dp_cmd),
        .o_stat    (dp_stat),
        .o_m_tdata (o_m_tdata)
    );

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
    import jpse_pkg::*;

    localparam int TABLE_DEPTH = NUM_ENTRIES_DEF;
    localparam int QUIET_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 50;
    localparam logic [OP_W-1:0] OP_UNKNOWN = 2'd3;

    // One slave beat, lowest field in the lowest bits.
    typedef struct packed {
        logic [S_TDATA_W-S_USED_W-1:0] pad;
        logic [LEN_W-1:0]              len;
        logic [POS_W-1:0]              pos;
        logic [GROUP_W-1:0]            grp;
        logic [EIDX_W-1:0]             idx;
        logic [DATA_W-1:0]             payload;
        logic [ID_W-1:0]               id;
        logic [OP_W-1:0]               op;
    } t_beat;

    // One master beat.
    typedef struct packed {
        logic [M_TDATA_W-M_USED_W-1:0] pad;
        logic [COUNT_W-1:0]            count;
        logic [STATUS_W-1:0]           status;
        logic [DATA_W-1:0]             value;
    } t_reply;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_s_tvalid = 1'b0;
    logic                 o_s_tready;
    // opcode, can_id, frame_data, entry_index, entry_group, entry_pos, entry_len
    logic [S_TDATA_W-1:0] i_s_tdata = '0;
    logic                 o_m_tvalid;
    logic                 i_m_tready = 1'b0;
    // value, status, match_count
    logic [M_TDATA_W-1:0] o_m_tdata;

    // Shadow copy of the signal table.
    logic [GROUP_W-1:0] ent_group [TABLE_DEPTH];
    logic [POS_W-1:0]   ent_pos   [TABLE_DEPTH];
    logic [LEN_W-1:0]   ent_len   [TABLE_DEPTH];
    logic               ent_valid [TABLE_DEPTH] = '{default: 1'b0};
    logic [DATA_W-1:0]  ent_value [TABLE_DEPTH] = '{default: '0};

    t_reply table_replies[$];
    int     error_count = 0;
    int     quiet_cycles = 0;
    int     send_idle_pct = 12;
    int     recv_idle_pct = 45;
    int     tready_hold = 0;
    logic [GROUP_W-1:0] group_pool [6];

    j1939_pgn_signal_extractor_top #(
        .NUM_ENTRIES(TABLE_DEPTH)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Group number of an identifier; the destination byte drops out below PF 0xF0.
    function automatic logic [GROUP_W-1:0] group_of_id(input logic [ID_W-1:0] id);
        logic [GROUP_W-1:0] g;
        g = id[25:8];
        if (id[23:16] < PF_LIMIT) begin
            g = g & GROUP_PDU1_MASK;
        end
        return g;
    endfunction

    // Bit field of the payload; lengths of 64 and above keep the whole shifted payload.
    function automatic logic [DATA_W-1:0] field_of(input logic [DATA_W-1:0] payload,
                                                   input logic [POS_W-1:0] pos,
                                                   input logic [LEN_W-1:0] len);
        logic [DATA_W-1:0] v;
        if (len == '0) begin
            return '0;
        end
        v = payload >> pos;
        if (len < LEN_W'(DATA_W)) begin
            v = v & ((DATA_W'(1) << len) - 1'b1);
        end
        return v;
    endfunction

    // Applies one beat to the shadow table and returns the reply it causes.
    function automatic t_reply apply_table_op(input t_beat b);
        t_reply r;
        logic [GROUP_W-1:0] g;
        logic idx_ok;
        r = '0;
        r.status = STATUS_OK;
        idx_ok = (b.idx != '0) && (int'(b.idx) < TABLE_DEPTH);
        case (b.op)
            OP_FRAME: begin
                g = group_of_id(b.id);
                for (int i = 1; i < TABLE_DEPTH; i++) begin
                    if (ent_valid[i] && ent_group[i] == g) begin
                        ent_value[i] = field_of(b.payload, ent_pos[i], ent_len[i]);
                        if (r.count < COUNT_MAX) begin
                            r.count = r.count + 1'b1;
                        end
                    end
                end
            end
            OP_READ: begin
                if (idx_ok && ent_valid[b.idx]) begin
                    r.value = ent_value[b.idx];
                end else begin
                    r.status = STATUS_ERR;
                end
            end
            OP_PROG: begin
                if (idx_ok) begin
                    ent_group[b.idx] = b.grp;
                    ent_pos[b.idx]   = b.pos;
                    ent_len[b.idx]   = b.len;
                    ent_valid[b.idx] = 1'b1;
                    ent_value[b.idx] = '0;
                end else begin
                    r.status = STATUS_ERR;
                end
            end
            default: begin
                r.status = STATUS_ERR;
            end
        endcase
        return r;
    endfunction

    // Checks each result beat against the oldest prediction, then predicts accepted beats.
    always @(posedge i_clk) begin : result_check
        t_reply got;
        t_reply want;
        logic   moved;
        moved = 1'b0;
        if (i_rst_n) begin
            if (o_m_tvalid && i_m_tready) begin
                moved = 1'b1;
                got = o_m_tdata;
                if (table_replies.size() == 0) begin
                    $error("result beat with no prediction pending: %h", o_m_tdata);
                    error_count++;
                end else begin
                    want = table_replies.pop_front();
                    if (got.value !== want.value) begin
                        $error("value mismatch: expected %h, got %h", want.value, got.value);
                        error_count++;
                    end
                    if (got.status !== want.status) begin
                        $error("status mismatch: expected %h, got %h",
                               want.status, got.status);
                        error_count++;
                    end
                    if (got.count !== want.count) begin
                        $error("match_count mismatch: expected %0d, got %0d",
                               want.count, got.count);
                        error_count++;
                    end
                end
            end
            if (i_s_tvalid && o_s_tready) begin
                moved = 1'b1;
                table_replies.push_back(apply_table_op(t_beat'(i_s_tdata)));
            end
        end
        quiet_cycles <= moved ? 0 : quiet_cycles + 1;
    end

    // Ends the run when nothing moves on either side for too long.
    initial begin : watchdog
        while (quiet_cycles < QUIET_LIMIT) begin
            @(posedge i_clk);
        end
        $display("== FAIL ==");
        $finish;
    end

    // Master-side ready: random stalls, or a long hold-off when one is requested.
    initial begin : receiver
        forever begin
            @(negedge i_clk);
            if (tready_hold > 0) begin
                tready_hold--;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    // Offers one beat, with random idle cycles ahead of it, and waits for its accept.
    task automatic send_beat(input t_beat b);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            @(negedge i_clk);
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        @(negedge i_clk);
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= b;
        @(posedge i_clk);
        while (!o_s_tready) begin
            @(posedge i_clk);
        end
    endtask

    // Stops offering and waits until every predicted result has arrived.
    task automatic wait_drained();
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        while (table_replies.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    function automatic t_beat rand_beat();
        t_beat b;
        b = S_TDATA_W'({$urandom, $urandom, $urandom, $urandom, $urandom});
        b.pad = '0;
        return b;
    endfunction

    function automatic t_beat mk_prog(input logic [EIDX_W-1:0] idx,
                                      input logic [GROUP_W-1:0] grp,
                                      input logic [POS_W-1:0] pos,
                                      input logic [LEN_W-1:0] len);
        t_beat b;
        b = rand_beat();
        b.op  = OP_PROG;
        b.idx = idx;
        b.grp = grp;
        b.pos = pos;
        b.len = len;
        return b;
    endfunction

    function automatic t_beat mk_frame(input logic [ID_W-1:0] id,
                                       input logic [DATA_W-1:0] payload);
        t_beat b;
        b = rand_beat();
        b.op      = OP_FRAME;
        b.id      = id;
        b.payload = payload;
        return b;
    endfunction

    function automatic t_beat mk_read(input logic [EIDX_W-1:0] idx);
        t_beat b;
        b = rand_beat();
        b.op  = OP_READ;
        b.idx = idx;
        return b;
    endfunction

    // Random identifier that carries the given group; PDU1 groups get a random destination.
    function automatic logic [ID_W-1:0] id_for_group(input logic [GROUP_W-1:0] g);
        logic [ID_W-1:0] id;
        id = ID_W'($urandom);
        id[25:8] = g;
        if (g[15:8] < PF_LIMIT) begin
            id[15:8] = 8'($urandom);
        end
        return id;
    endfunction

    // Signal lengths: mostly legal, with zero and oversize lengths mixed in.
    function automatic logic [LEN_W-1:0] rand_len();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return LEN_W'($urandom_range(65, 127));
            2: return LEN_W'(DATA_W);
            default: return LEN_W'($urandom_range(1, 63));
        endcase
    endfunction

    // Empty table, the reserved index, the unknown opcode and a frame on the empty table.
    task automatic test_unprogrammed_and_errors();
        t_beat b;
        send_beat(mk_read(5'd5));
        send_beat(mk_read(5'd0));
        send_beat(mk_prog(5'd0, 18'h3FFFF, 6'd0, 7'd8));
        b = rand_beat();
        b.op = OP_UNKNOWN;
        send_beat(b);
        send_beat(mk_frame(29'h1FFFFFFF, '1));
    endtask

    // Field extremes on PDU1 and PDU2 groups, then reprogramming an entry.
    task automatic test_directed_extraction();
        send_beat(mk_prog(5'd1, 18'h3EF00, 6'd0, 7'd64));
        send_beat(mk_prog(5'd2, 18'h3EF00, 6'd63, 7'd1));
        send_beat(mk_prog(5'd3, 18'h3EF00, 6'd60, 7'd8));
        send_beat(mk_prog(5'd4, 18'h3EF00, 6'd0, 7'd0));
        send_beat(mk_prog(5'd5, 18'h3EF00, 6'd5, 7'd127));
        send_beat(mk_prog(5'd6, 18'h0F012, 6'd8, 7'd16));
        send_beat(mk_prog(5'd31, 18'h3FFFF, 6'd32, 7'd65));
        // PF 0xEF with a nonzero destination still hits the PDU1 group.
        send_beat(mk_frame({3'b111, 2'b11, 8'hEF, 8'h55, 8'hA3}, '1));
        for (int i = 1; i <= 5; i++) begin
            send_beat(mk_read(EIDX_W'(i)));
        end
        send_beat(mk_frame({3'b000, 2'b11, 8'hEF, 8'h00, 8'h00}, 64'h8000_0000_0000_0001));
        send_beat(mk_read(5'd1));
        // PF 0xF0 is the first PDU2 format.
        send_beat(mk_frame({3'b010, 2'b00, 8'hF0, 8'h12, 8'hFF}, 64'h0123_4567_89AB_CDEF));
        send_beat(mk_read(5'd6));
        send_beat(mk_frame(29'h1FFFFFFF, 64'hF0E1_D2C3_B4A5_9687));
        send_beat(mk_read(5'd31));
        send_beat(mk_frame({3'b000, 2'b01, 8'h00, 8'hFF, 8'h00}, '1));
        send_beat(mk_prog(5'd1, 18'h3EF00, 6'd7, 7'd9));
        send_beat(mk_read(5'd1));
    endtask

    // Every entry on one group while the master holds off, so the input stalls.
    task automatic test_full_table_backpressure();
        logic [GROUP_W-1:0] g;
        g = GROUP_W'($urandom);
        g[15:8] = 8'($urandom_range(PF_LIMIT, BYTE_MASK));
        @(posedge i_clk);
        tready_hold = 400;
        for (int i = 1; i < TABLE_DEPTH; i++) begin
            send_beat(mk_prog(EIDX_W'(i), g, POS_W'($urandom), rand_len()));
        end
        send_beat(mk_frame(id_for_group(g), {$urandom, $urandom}));
        for (int i = 0; i < 5; i++) begin
            send_beat(mk_read(EIDX_W'($urandom_range(1, TABLE_DEPTH - 1))));
        end
    endtask

    // Mostly frames and reads on a small set of programmed groups, with noise mixed in.
    task automatic test_random_traffic(input int n, input int s_pct, input int r_pct);
        t_beat b;
        logic [GROUP_W-1:0] g;
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        foreach (group_pool[k]) begin
            g = GROUP_W'($urandom);
            if (k % 2 == 0) begin
                g[15:8] = 8'($urandom_range(PF_LIMIT, BYTE_MASK));
            end else if (g[15:8] < PF_LIMIT) begin
                g[7:0] = '0;
            end
            group_pool[k] = g;
        end
        for (int i = 0; i < n; i++) begin
            g = group_pool[$urandom_range(0, 5)];
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4: begin
                    if ($urandom_range(0, 9) == 0) begin
                        g = GROUP_W'($urandom);
                    end
                    b = mk_prog(EIDX_W'($urandom_range(0, TABLE_DEPTH - 1)), g,
                                POS_W'($urandom), rand_len());
                end
                5, 6, 7, 8, 9, 10, 11, 12, 13: begin
                    b = mk_frame($urandom_range(0, 4) == 0 ? ID_W'($urandom) : id_for_group(g),
                                 $urandom_range(0, 9) == 0 ? {DATA_W{$urandom_range(0, 1) == 1}}
                                                           : {$urandom, $urandom});
                end
                19: begin
                    b = rand_beat();
                    b.op = OP_UNKNOWN;
                end
                default: begin
                    b = mk_read(EIDX_W'($urandom_range(0, 9) == 0 ? 0
                                                                  : $urandom_range(1, 31)));
                end
            endcase
            send_beat(b);
        end
    endtask

    // Test sequence.
    initial begin : stimulus
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_unprogrammed_and_errors();
        test_directed_extraction();
        wait_drained();
        test_full_table_backpressure();
        wait_drained();
        test_random_traffic(170, 12, 45);
        wait_drained();
        test_random_traffic(170, 45, 12);
        wait_drained();
        test_random_traffic(170, 0, 0);
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (table_replies.size() != 0) begin
            $error("%0d predicted results never arrived", table_replies.size());
            error_count++;
        end
        if (error_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
